// ===== hdl/pcm_frame_volume_upsampler_core_macros.svh =====
// Assertion macros shared by the upsampler RTL.
`ifndef PCM_FRAME_VOLUME_UPSAMPLER_CORE_MACROS_SVH
`define PCM_FRAME_VOLUME_UPSAMPLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PFVU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFVU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pfvu_pkg.sv =====
// Package with register map, reset values and widths of the upsampler.
`default_nettype none

package pfvu_pkg;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_SAMPLE_IS_16BIT = 2'd0;
  localparam logic [1:0] REG_STEREO          = 2'd1;
  localparam logic [1:0] REG_VOLUME          = 2'd2;
  localparam logic [1:0] REG_UPSAMPLE_SHIFT  = 2'd3;

  // Register reset values
  localparam logic       RST_SAMPLE_IS_16BIT = 1'b1;
  localparam logic       RST_STEREO          = 1'b1;
  localparam logic [7:0] RST_VOLUME          = 8'd200;
  localparam logic [1:0] RST_UPSAMPLE_SHIFT  = 2'd0;

  // Largest supported shift code; higher codes saturate to it
  localparam logic [1:0] MAX_SHIFT = 2'd2;

  // 8-bit samples are centered by flipping the top bit (value - 128)
  localparam logic [7:0] CENTER_MASK = 8'h80;

endpackage

`default_nettype wire

// ===== hdl/pcm_frame_volume_upsampler_core.sv =====
// Top level: PCM frame decode, volume scaling and linear-interpolation upsampler.
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  --------------------------------------
//  frame     in         frame_valid / frame_stall  frame_bytes, clear_history
//  sample    out        sample_valid/sample_stall  left_sample, right_sample, last_of_run
//  config    in         APB psel/penable/pwrite    paddr[3:2] register, pwdata, prdata
//
//  Each frame gives 1, 2 or 4 output transactions (factor = 2^upsample_shift, code 3 as 4),
//  one per cycle unless the output stalls; the run counter in the interpolation stage counts
//  them. A frame passes the frame, run and output registers before its first output.
//  Reset (rst, synchronous) restores the register defaults and clears the stored samples.
//  A stall on the output holds the output register; the frame register still accepts one
//  transaction while a run is in progress or a result waits.
`default_nettype none

module pcm_frame_volume_upsampler_core (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // frame input
  input  wire logic               frame_valid,
  output logic                    frame_stall,
  input  wire logic [31:0]        frame_bytes,
  input  wire logic               clear_history,
  // sample output
  output logic                    sample_valid,
  input  wire logic               sample_stall,
  output logic signed [15:0]      left_sample,
  output logic signed [15:0]      right_sample,
  output logic                    last_of_run
);

  // Configuration registers
  logic       sample_is_16bit;
  logic       stereo;
  logic [7:0] volume;
  logic [1:0] upsample_shift;

  logic       cfg_write;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_is_16bit <= pfvu_pkg::RST_SAMPLE_IS_16BIT;
      stereo          <= pfvu_pkg::RST_STEREO;
      volume          <= pfvu_pkg::RST_VOLUME;
      upsample_shift  <= pfvu_pkg::RST_UPSAMPLE_SHIFT;
    end else if (cfg_write) begin
      case (paddr[3:2])
        pfvu_pkg::REG_SAMPLE_IS_16BIT: sample_is_16bit <= pwdata[0];
        pfvu_pkg::REG_STEREO:          stereo          <= pwdata[0];
        pfvu_pkg::REG_VOLUME:          volume          <= pwdata[7:0];
        pfvu_pkg::REG_UPSAMPLE_SHIFT:  upsample_shift  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[3:2])
      pfvu_pkg::REG_SAMPLE_IS_16BIT: prdata = {31'd0, sample_is_16bit};
      pfvu_pkg::REG_STEREO:          prdata = {31'd0, stereo};
      pfvu_pkg::REG_VOLUME:          prdata = {24'd0, volume};
      pfvu_pkg::REG_UPSAMPLE_SHIFT:  prdata = {30'd0, upsample_shift};
      default:                       prdata = 32'd0;
    endcase
  end

  // Effective shift and last run index
  logic [1:0] shift_eff;
  logic [1:0] last_idx;
  assign shift_eff = (upsample_shift >= pfvu_pkg::MAX_SHIFT) ? pfvu_pkg::MAX_SHIFT
                                                            : upsample_shift;
  always_comb begin
    case (shift_eff)
      2'd0:    last_idx = 2'd0;
      2'd1:    last_idx = 2'd1;
      default: last_idx = 2'd3;
    endcase
  end

  // ---------------------------------------------------------------- stage 1
  logic        s1_valid;
  logic [31:0] s1_bytes;
  logic        s1_clear;
  logic        s1_move;

  logic        run_valid;
  logic [1:0]  run_idx;
  logic        run_done;
  logic        out_load;

  assign out_load    = run_valid && (!sample_valid || !sample_stall);
  assign run_done    = out_load && (run_idx == last_idx);
  assign s1_move     = s1_valid && (!run_valid || run_done);
  assign frame_stall = s1_valid && !s1_move;

  // Capture a frame transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!frame_stall) begin
      s1_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && !frame_stall) begin
      s1_bytes <= frame_bytes;
      s1_clear <= clear_history;
    end
  end

  // Decode samples from the frame bytes
  logic signed [15:0] samp_l;
  logic signed [15:0] samp_r;
  always_comb begin
    if (sample_is_16bit) begin
      samp_l = $signed(s1_bytes[15:0]);
      samp_r = stereo ? $signed(s1_bytes[31:16]) : $signed(s1_bytes[15:0]);
    end else begin
      samp_l = $signed({s1_bytes[7:0] ^ pfvu_pkg::CENTER_MASK, 8'h00});
      samp_r = stereo ? $signed({s1_bytes[15:8] ^ pfvu_pkg::CENTER_MASK, 8'h00})
                      : $signed({s1_bytes[7:0] ^ pfvu_pkg::CENTER_MASK, 8'h00});
    end
  end

  // Scale by volume, floor shift by eight
  logic signed [8:0]  vol_s;
  logic signed [24:0] prod_l;
  logic signed [24:0] prod_r;
  logic signed [15:0] scaled_l;
  logic signed [15:0] scaled_r;
  assign vol_s    = $signed({1'b0, volume});
  assign prod_l   = samp_l * vol_s;
  assign prod_r   = samp_r * vol_s;
  assign scaled_l = prod_l[23:8];
  assign scaled_r = prod_r[23:8];

  // Stored previous frame, zeroed by the clear flag
  logic signed [15:0] previous_left;
  logic signed [15:0] previous_right;
  logic signed [15:0] base_l;
  logic signed [15:0] base_r;
  assign base_l = s1_clear ? 16'sd0 : previous_left;
  assign base_r = s1_clear ? 16'sd0 : previous_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_left  <= 16'sd0;
      previous_right <= 16'sd0;
    end else if (s1_move) begin
      previous_left  <= scaled_l;
      previous_right <= scaled_r;
    end
  end

  // ---------------------------------------------------------- run stage
  logic signed [15:0] run_base_l;
  logic signed [15:0] run_base_r;
  logic signed [16:0] run_diff_l;
  logic signed [16:0] run_diff_r;

  // Advance the run counter, reload from stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_idx   <= 2'd0;
    end else if (s1_move) begin
      run_valid <= 1'b1;
      run_idx   <= 2'd0;
    end else if (run_done) begin
      run_valid <= 1'b0;
    end else if (out_load) begin
      run_idx   <= run_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      run_base_l <= base_l;
      run_base_r <= base_r;
      run_diff_l <= {scaled_l[15], scaled_l} - {base_l[15], base_l};
      run_diff_r <= {scaled_r[15], scaled_r} - {base_r[15], base_r};
    end
  end

  // Interpolate: base + trunc(diff * k / factor)
  logic signed [3:0]  k_s;
  logic signed [19:0] num_l;
  logic signed [19:0] num_r;
  logic signed [19:0] bias;
  logic signed [19:0] quo_l;
  logic signed [19:0] quo_r;
  logic signed [15:0] interp_l;
  logic signed [15:0] interp_r;

  assign k_s   = $signed({2'b00, run_idx} + 4'd1);
  assign num_l = run_diff_l * k_s;
  assign num_r = run_diff_r * k_s;
  assign bias  = $signed((20'd1 << shift_eff) - 20'd1);
  assign quo_l = (num_l + (num_l[19] ? bias : 20'sd0)) >>> shift_eff;
  assign quo_r = (num_r + (num_r[19] ? bias : 20'sd0)) >>> shift_eff;
  assign interp_l = run_base_l + quo_l[15:0];
  assign interp_r = run_base_r + quo_r[15:0];

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || !sample_stall) begin
      sample_valid <= run_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_sample  <= interp_l;
      right_sample <= interp_r;
      last_of_run  <= (run_idx == last_idx);
    end
  end

  // ------------------------------------------------------------ assertions
`include "pcm_frame_volume_upsampler_core_macros.svh"

  `PFVU_ASSERT_NOW(a_idx_in_range, run_valid, run_idx <= last_idx, "run index past factor")
  `PFVU_ASSERT_NEXT(a_run_start, s1_move, run_valid && run_idx == 2'd0, "run did not start")
  `PFVU_ASSERT_NEXT(a_step, out_load && !run_done, run_idx == $past(run_idx) + 2'd1, "no step")
  `PFVU_ASSERT_NEXT(a_run_end, run_done && !s1_move, !run_valid, "run did not end")

endmodule

`default_nettype wire
